@@ hw/rtl/tpc_pkg.sv @@
// Shared types and constants for the throttle PI controller.
// Depends on nothing; imported by the datapath, controller and top level.
`default_nettype none

package tpc_pkg;

    // Sample width of the ADC readouts (sign taken from the top bit)
    localparam int SAMPLE_WIDTH = 16;

    // Q16.16 unity
    localparam int Q_ONE = 65536;

    // Configuration port geometry
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_PEDAL_SCALE    = 3'd0,
        REG_THROTTLE_SCALE = 3'd1,
        REG_GAIN_CURRENT   = 3'd2,
        REG_GAIN_PREVIOUS  = 3'd3,
        REG_COMP_OFFSET    = 3'd4,
        REG_PWM_STEPS      = 3'd5
    } cfg_reg_t;

    // Input transaction payload
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] pedal_sample;
        logic signed [SAMPLE_WIDTH-1:0] throttle_sample;
    } item_t;

    // Output transaction payload
    typedef struct packed {
        logic signed [17:0] control_output;
        logic               clamped;
        logic        [14:0] duty_magnitude;
        logic               duty_negative;
    } result_t;

    // Operand selection of the shared multiplier
    typedef enum logic [2:0] {
        MUL_NONE     = 3'd0,
        MUL_PEDAL    = 3'd1,
        MUL_THROTTLE = 3'd2,
        MUL_PREVIOUS = 3'd3,
        MUL_CURRENT  = 3'd4,
        MUL_DUTY     = 3'd5
    } mul_sel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic     capture;     // latch the input samples
        mul_sel_t mul_sel;     // multiplier operands this cycle
        logic     ld_pedal;    // store pedal position
        logic     ld_error;    // store saturated error
        logic     ld_acc;      // store state minus previous-error term
        logic     ld_update;   // finish the update, clamp, write state
        logic     ld_result;   // load the output register
    } dp_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/tpc_datapath.sv @@
// Datapath of the throttle PI controller: config registers, shared
// multiplier, control state and output register. Depends on tpc_pkg.
`default_nettype none

module tpc_datapath
    import tpc_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    input  wire item_t                      item_data,
    input  wire dp_cmd_t                    cmd,
    output result_t                         result_data
);

    // Configuration registers
    logic        [23:0] pedal_scale_reg;
    logic        [23:0] throttle_scale_reg;
    logic signed [31:0] gain_current_reg;
    logic signed [31:0] gain_previous_reg;
    logic signed [17:0] comp_offset_reg;
    logic        [14:0] pwm_steps_reg;

    // Controller state
    logic signed [31:0] previous_error_reg;
    logic signed [31:0] control_state_reg;

    // Working registers
    logic signed [SAMPLE_WIDTH-1:0] pedal_sample_reg;
    logic signed [SAMPLE_WIDTH-1:0] throttle_sample_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] pedal_pos_reg;
    logic signed [31:0] error_reg;
    logic signed [48:0] acc_reg;
    logic signed [17:0] y_reg;
    logic               clamped_reg;
    result_t            result_reg;

    // Combinational signals
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [31:0] thr_position;
    logic signed [32:0] diff;
    logic signed [31:0] error_next;
    logic signed [47:0] gain_term;
    logic signed [48:0] acc_next;
    logic signed [49:0] sum;
    logic signed [31:0] ctrl_sat;
    logic signed [32:0] y_raw;
    logic signed [17:0] y_next;
    logic               clamped_next;
    logic signed [31:0] ctrl_next;
    logic signed [17:0] y_neg;
    logic        [16:0] mag;
    logic        [15:0] duty_full;
    logic        [14:0] duty;

    // Write configuration registers; unknown indexes fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pedal_scale_reg    <= '0;
            throttle_scale_reg <= '0;
            gain_current_reg   <= '0;
            gain_previous_reg  <= '0;
            comp_offset_reg    <= '0;
            pwm_steps_reg      <= 15'd1000;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PEDAL_SCALE:    pedal_scale_reg    <= cfg_data[23:0];
                REG_THROTTLE_SCALE: throttle_scale_reg <= cfg_data[23:0];
                REG_GAIN_CURRENT:   gain_current_reg   <= cfg_data;
                REG_GAIN_PREVIOUS:  gain_previous_reg  <= cfg_data;
                REG_COMP_OFFSET:    comp_offset_reg    <= cfg_data[17:0];
                REG_PWM_STEPS:      pwm_steps_reg      <= cfg_data[14:0];
                default:            ;
            endcase
        end
    end

    // Select multiplier operands
    always_comb
    begin
        y_neg = -y_reg;
        mag   = y_reg[17] ? y_neg[16:0] : y_reg[16:0];
        case (cmd.mul_sel)
            MUL_PEDAL:
            begin
                mul_a = 32'(pedal_sample_reg);
                mul_b = {8'd0, pedal_scale_reg};
            end
            MUL_THROTTLE:
            begin
                mul_a = 32'(throttle_sample_reg);
                mul_b = {8'd0, throttle_scale_reg};
            end
            MUL_PREVIOUS:
            begin
                mul_a = gain_previous_reg;
                mul_b = previous_error_reg;
            end
            MUL_CURRENT:
            begin
                mul_a = gain_current_reg;
                mul_b = error_reg;
            end
            MUL_DUTY:
            begin
                mul_a = {15'd0, mag};
                mul_b = {17'd0, pwm_steps_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Error, accumulation and clamp arithmetic
    always_comb
    begin
        // Arithmetic shift of the product gives floor rounding
        thr_position = prod_reg[39:8];
        diff         = 33'(pedal_pos_reg) - 33'(thr_position);
        if (diff[32] != diff[31])
            error_next = diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            error_next = diff[31:0];

        gain_term = prod_reg[63:16];
        acc_next  = 49'(control_state_reg) - 49'(gain_term);

        // Saturate the updated state to 32 bits
        sum = 50'(acc_reg) + 50'(gain_term);
        if (sum[49:31] != {19{sum[49]}})
            ctrl_sat = sum[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            ctrl_sat = sum[31:0];

        // Clamp output to plus or minus one, pull the state back on a clamp
        y_raw = 33'(ctrl_sat) + 33'(comp_offset_reg);
        if (y_raw > 33'(Q_ONE))
        begin
            y_next       = 18'(Q_ONE);
            ctrl_next    = 32'(Q_ONE) - 32'(comp_offset_reg);
            clamped_next = 1'b1;
        end
        else if (y_raw < -33'(Q_ONE))
        begin
            y_next       = -18'(Q_ONE);
            ctrl_next    = -32'(Q_ONE) - 32'(comp_offset_reg);
            clamped_next = 1'b1;
        end
        else
        begin
            y_next       = y_raw[17:0];
            ctrl_next    = ctrl_sat;
            clamped_next = 1'b0;
        end

        // Truncate duty and limit it to the step count
        duty_full = prod_reg[31:16];
        if (duty_full > {1'b0, pwm_steps_reg})
            duty = pwm_steps_reg;
        else
            duty = duty_full[14:0];
    end

    // Hold the controller state across ticks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_error_reg <= '0;
            control_state_reg  <= '0;
        end
        else if (cmd.ld_update)
        begin
            previous_error_reg <= error_reg;
            control_state_reg  <= ctrl_next;
        end
    end

    // Advance the working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.capture)
        begin
            pedal_sample_reg    <= item_data.pedal_sample;
            throttle_sample_reg <= item_data.throttle_sample;
        end
        if (cmd.ld_pedal)
            pedal_pos_reg <= prod_reg[39:8];
        if (cmd.ld_error)
            error_reg <= error_next;
        if (cmd.ld_acc)
            acc_reg <= acc_next;
        if (cmd.ld_update)
        begin
            y_reg       <= y_next;
            clamped_reg <= clamped_next;
        end
        if (cmd.ld_result)
        begin
            result_reg.control_output <= y_reg;
            result_reg.clamped        <= clamped_reg;
            result_reg.duty_magnitude <= duty;
            result_reg.duty_negative  <= y_reg[17];
        end
    end

    assign result_data = result_reg;

endmodule

`default_nettype wire

@@ hw/rtl/tpc_ctrl.sv @@
// Sequencer of the throttle PI controller: steps the shared multiplier
// through one tick and owns both handshakes. Depends on tpc_pkg.
`default_nettype none

module tpc_ctrl
    import tpc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic item_valid,
    output logic      item_stall,
    output logic      result_valid,
    input  wire logic result_stall,
    output dp_cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PEDAL,
        S_THROTTLE,
        S_ERROR,
        S_PREVIOUS,
        S_UPDATE,
        S_DUTY,
        S_OUT
    } state_t;

    state_t state_reg;
    logic   result_valid_reg;
    logic   accept;
    logic   out_free;

    assign item_stall   = (state_reg != S_IDLE);
    assign accept       = item_valid && !item_stall;
    assign out_free     = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;

    // Decode datapath commands from the state
    always_comb
    begin
        cmd           = '0;
        cmd.mul_sel   = MUL_NONE;
        case (state_reg)
            S_IDLE:     cmd.capture = accept;
            S_PEDAL:    cmd.mul_sel = MUL_PEDAL;
            S_THROTTLE:
            begin
                cmd.mul_sel  = MUL_THROTTLE;
                cmd.ld_pedal = 1'b1;
            end
            S_ERROR:
            begin
                cmd.mul_sel  = MUL_PREVIOUS;
                cmd.ld_error = 1'b1;
            end
            S_PREVIOUS:
            begin
                cmd.mul_sel = MUL_CURRENT;
                cmd.ld_acc  = 1'b1;
            end
            S_UPDATE:   cmd.ld_update = 1'b1;
            S_DUTY:     cmd.mul_sel   = MUL_DUTY;
            S_OUT:
            begin
                // Keep the duty product in place while the output waits
                cmd.mul_sel   = MUL_DUTY;
                cmd.ld_result = out_free;
            end
            default:    ;
        endcase
    end

    // Hold state and the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:     if (accept) state_reg <= S_PEDAL;
                S_PEDAL:    state_reg <= S_THROTTLE;
                S_THROTTLE: state_reg <= S_ERROR;
                S_ERROR:    state_reg <= S_PREVIOUS;
                S_PREVIOUS: state_reg <= S_UPDATE;
                S_UPDATE:   state_reg <= S_DUTY;
                S_DUTY:     state_reg <= S_OUT;
                S_OUT:      if (out_free) state_reg <= S_IDLE;
                default:    state_reg <= S_IDLE;
            endcase

            if (cmd.ld_result)
                result_valid_reg <= 1'b1;
            else if (result_valid_reg && !result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // A result never overwrites one still waiting to be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ld_result |-> (!result_valid_reg || !result_stall))
        else $error("result loaded over a pending transaction");

    // An accepted transaction starts the multiply sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_PEDAL) && item_stall)
        else $error("accepted transaction did not start the sequence");

    // Result valid rises only after the output state loads it
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result valid rose outside the output state");

    // State is written once per tick, in the update step, ahead of the duty and output states
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ld_update |=> ##1 (state_reg == S_OUT))
        else $error("update and output out of step");

endmodule

`default_nettype wire

@@ hw/rtl/throttle_pi_controller_core.sv @@
// Throttle PI controller, top level: joins the sequencer and the datapath.
// Depends on tpc_pkg, tpc_ctrl and tpc_datapath.
//
// Use:
//   item channel (item_valid / item_stall / item_data) carries one control
//   tick: a pedal and a throttle ADC sample. result channel
//   (result_valid / result_stall / result_data) returns one transaction per
//   tick: clamped output, clamp flag, duty magnitude and duty sign.
//   cfg_write / cfg_index / cfg_data write one register per cycle; write
//   only while no tick is in flight. Indexes above 5 are ignored.
// Sequence:
//   One 32x32 multiplier is shared over five products, so a tick steps
//   through the pedal, throttle, error, previous, update, duty and output
//   states; a new tick is taken only once the previous one is done (item_stall is high while busy).
// Stall:
//   The finished result sits in an output register; the next tick is
//   accepted and computed meanwhile, and waits in its last step until the
//   earlier result is taken.
// Reset:
//   rst_n clears the controller state (previous error, control state), the
//   gains, scales and offset to zero and the step count to 1000.
`default_nettype none

module throttle_pi_controller_core
    import tpc_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       item_valid,
    output logic                            item_stall,
    input  wire item_t                      item_data,
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output result_t                         result_data,
    input  wire logic                       cfg_write,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    dp_cmd_t cmd;

    // Sequence one tick
    tpc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd)
    );

    // Compute the update
    tpc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_data   (item_data),
        .cmd         (cmd),
        .result_data (result_data)
    );

endmodule

`default_nettype wire
